/* rtl/dps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types and constants of the Doppler pitch smoother.
// ----------------------------------------------------------------------------
package dps_pkg;

	localparam int IN_W    = 272;
	localparam int OUT_W   = 24;
	localparam int CFG_W   = 24;
	localparam int CFG_A_W = 3;

	localparam logic [CFG_A_W-1:0] CFG_INTENSITY = 3'd0;
	localparam logic [CFG_A_W-1:0] CFG_SMOOTH_ON = 3'd1;
	localparam logic [CFG_A_W-1:0] CFG_SPEED     = 3'd2;
	localparam logic [CFG_A_W-1:0] CFG_VLIMIT    = 3'd3;
	localparam logic [CFG_A_W-1:0] CFG_PMAX      = 3'd4;
	localparam logic [CFG_A_W-1:0] CFG_TICK      = 3'd5;

	localparam logic [23:0] RST_INTENSITY = 24'd65536;
	localparam logic [23:0] RST_SPEED     = 24'd327680;
	localparam logic [14:0] RST_VLIMIT    = 15'd32000;
	localparam logic [18:0] RST_PMAX      = 19'd65536;
	localparam logic [15:0] RST_TICK      = 16'd1092;

	localparam logic signed [19:0] PITCH_ONE = 20'sd65536;
	localparam logic [32:0]        SOUND_Q16 = 33'd2162688000; // 33000 * 65536
	localparam logic [20:0]        SNAP_GAP  = 21'd6;
	localparam logic [4:0]         SQRT_STEPS = 5'd30;          // 31 steps
	localparam logic [4:0]         DIV_STEPS  = 5'd31;          // 32 steps

	typedef struct packed {
		logic [23:0] intensity;
		logic        smooth_on;
		logic [23:0] speed;
		logic [14:0] vlimit;
		logic [18:0] pmax;
		logic [15:0] tick;
	} cfg_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SHIFT,
		OP_MUL_SQ,
		OP_ACC_SQ,
		OP_MUL_DOT,
		OP_ACC_DOT,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_MUL_LIM,
		OP_CMP_LIM,
		OP_DIV1_INIT,
		OP_DIV_STEP,
		OP_DIV2_INIT,
		OP_MUL_SC,
		OP_TGT,
		OP_MUL_ALPHA,
		OP_ALPHA,
		OP_MUL_GAP,
		OP_FINAL
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_SQ_MUL,
		ST_SQ_ACC,
		ST_DOT_MUL,
		ST_DOT_ACC,
		ST_SQRT_INIT,
		ST_SQRT,
		ST_LIM_MUL,
		ST_LIM_CMP,
		ST_DIV1_INIT,
		ST_DIV,
		ST_DIV2_INIT,
		ST_SC_MUL,
		ST_TGT,
		ST_ALPHA_MUL,
		ST_ALPHA,
		ST_GAP_MUL,
		ST_FINAL
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic vsat;
		logic out_free;
	} stat_t;

endpackage

/* rtl/dps_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_ctrl
// Sequencer: steps the datapath through one transaction.
// ----------------------------------------------------------------------------
module dps_ctrl import dps_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t     state_q, state_d;
	logic [1:0] idx_q, idx_d;
	logic [4:0] cnt_q, cnt_d;
	logic       pass_q, pass_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= 2'd0;
			cnt_q   <= 5'd0;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			pass_q  <= pass_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		cnt_d    = cnt_q;
		pass_d   = pass_q;
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		cmd.idx  = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				cmd.op  = OP_SHIFT;
				idx_d   = 2'd0;
				state_d = ST_SQ_MUL;
			end
			ST_SQ_MUL: begin
				cmd.op  = OP_MUL_SQ;
				state_d = ST_SQ_ACC;
			end
			ST_SQ_ACC: begin
				cmd.op  = OP_ACC_SQ;
				state_d = ST_DOT_MUL;
			end
			ST_DOT_MUL: begin
				cmd.op  = OP_MUL_DOT;
				state_d = ST_DOT_ACC;
			end
			ST_DOT_ACC: begin
				cmd.op = OP_ACC_DOT;
				if (idx_q == 2'd2) begin
					state_d = ST_SQRT_INIT;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = ST_SQ_MUL;
				end
			end
			ST_SQRT_INIT: begin
				cmd.op  = OP_SQRT_INIT;
				cnt_d   = SQRT_STEPS;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.op = OP_SQRT_STEP;
				if (cnt_q == 5'd0) begin
					state_d = ST_LIM_MUL;
				end else begin
					cnt_d = cnt_q - 5'd1;
				end
			end
			ST_LIM_MUL: begin
				cmd.op  = OP_MUL_LIM;
				state_d = ST_LIM_CMP;
			end
			ST_LIM_CMP: begin
				cmd.op  = OP_CMP_LIM;
				state_d = stat.vsat ? ST_DIV2_INIT : ST_DIV1_INIT;
			end
			ST_DIV1_INIT: begin
				cmd.op  = OP_DIV1_INIT;
				cnt_d   = DIV_STEPS;
				pass_d  = 1'b0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (cnt_q == 5'd0) begin
					state_d = pass_q ? ST_SC_MUL : ST_DIV2_INIT;
				end else begin
					cnt_d = cnt_q - 5'd1;
				end
			end
			ST_DIV2_INIT: begin
				cmd.op  = OP_DIV2_INIT;
				cnt_d   = DIV_STEPS;
				pass_d  = 1'b1;
				state_d = ST_DIV;
			end
			ST_SC_MUL: begin
				cmd.op  = OP_MUL_SC;
				state_d = ST_TGT;
			end
			ST_TGT: begin
				cmd.op  = OP_TGT;
				state_d = ST_ALPHA_MUL;
			end
			ST_ALPHA_MUL: begin
				cmd.op  = OP_MUL_ALPHA;
				state_d = ST_ALPHA;
			end
			ST_ALPHA: begin
				cmd.op  = OP_ALPHA;
				state_d = ST_GAP_MUL;
			end
			ST_GAP_MUL: begin
				cmd.op  = OP_MUL_GAP;
				state_d = ST_FINAL;
			end
			ST_FINAL: begin
				if (stat.out_free) begin
					cmd.op  = OP_FINAL;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* rtl/dps_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_dp
// Datapath: shared multiplier, square-root and divider recurrences, state.
// ----------------------------------------------------------------------------
module dps_dp import dps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output stat_t            stat,
	input  cfg_t             cfg,
	input  logic [IN_W-1:0]  in_data,
	output logic [OUT_W-1:0] out_data,
	output logic             out_valid,
	input  logic             out_ready
);

	logic signed [24:0] d_q   [3];
	logic signed [21:0] dv_q  [3];
	logic [19:0]        m_q   [3];
	logic               sgn_q [3];

	logic [41:0]        sacc_q;
	logic signed [44:0] dot_q;
	logic signed [49:0] prod_q;

	logic [61:0] n_q;
	logic [33:0] srem_q;
	logic [30:0] root_q;

	logic [33:0] rem_q;
	logic [31:0] low_q;
	logic [32:0] dvsr_q;

	logic        vsat_q, vneg_q;
	logic [30:0] vmag_q;
	logic signed [19:0] tgt_q, smooth_q, res_q;
	logic [16:0] alpha_q;
	logic        init_q, valid_q;

	// operand selection
	logic [19:0]        m_sel;
	logic               sgn_sel;
	logic signed [21:0] dv_sel;
	logic signed [20:0] ds_sel;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_full;

	always_comb begin
		case (cmd.idx)
			2'd1:    begin m_sel = m_q[1]; sgn_sel = sgn_q[1]; dv_sel = dv_q[1]; end
			2'd2:    begin m_sel = m_q[2]; sgn_sel = sgn_q[2]; dv_sel = dv_q[2]; end
			default: begin m_sel = m_q[0]; sgn_sel = sgn_q[0]; dv_sel = dv_q[0]; end
		endcase
		ds_sel = sgn_sel ? -$signed({1'b0, m_sel}) : $signed({1'b0, m_sel});
	end

	// gap toward target
	logic signed [20:0] gap;
	logic [20:0]        gap_mag;
	assign gap     = 21'(tgt_q) - 21'(smooth_q);
	assign gap_mag = gap[20] ? 21'(-gap) : 21'(gap);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_SQ: begin
				mul_a = $signed({13'd0, m_sel});
				mul_b = $signed({13'd0, m_sel});
			end
			OP_MUL_DOT: begin
				mul_a = 33'(dv_sel);
				mul_b = 33'(ds_sel);
			end
			OP_MUL_LIM: begin
				mul_a = $signed({18'd0, cfg.vlimit});
				mul_b = $signed({2'd0, root_q});
			end
			OP_MUL_SC: begin
				mul_a = $signed({9'd0, low_q[23:0]});
				mul_b = $signed({9'd0, cfg.intensity});
			end
			OP_MUL_ALPHA: begin
				mul_a = $signed({17'd0, cfg.tick});
				mul_b = $signed({9'd0, cfg.speed});
			end
			OP_MUL_GAP: begin
				mul_a = $signed({12'd0, gap_mag});
				mul_b = $signed({16'd0, alpha_q});
			end
			default: ;
		endcase
	end
	assign mul_full = mul_a * mul_b;

	// input unpack
	logic signed [23:0] sp [3];
	logic signed [23:0] lp [3];
	logic signed [20:0] sv [3];
	logic signed [20:0] lv [3];
	assign sp[0] = in_data[23:0];
	assign sp[1] = in_data[47:24];
	assign sp[2] = in_data[71:48];
	assign sv[0] = in_data[92:72];
	assign sv[1] = in_data[113:93];
	assign sv[2] = in_data[134:114];
	assign lp[0] = in_data[158:135];
	assign lp[1] = in_data[182:159];
	assign lp[2] = in_data[206:183];
	assign lv[0] = in_data[227:207];
	assign lv[1] = in_data[248:228];
	assign lv[2] = in_data[269:249];

	// common shift for the direction
	logic [23:0] dmag [3];
	logic [23:0] maxm;
	logic [2:0]  shamt;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dmag[i] = d_q[i][24] ? 24'(-d_q[i]) : 24'(d_q[i]);
		end
		maxm = dmag[0] | dmag[1] | dmag[2];
		if (maxm[23])      shamt = 3'd4;
		else if (maxm[22]) shamt = 3'd3;
		else if (maxm[21]) shamt = 3'd2;
		else if (maxm[20]) shamt = 3'd1;
		else               shamt = 3'd0;
	end

	// square-root and divide recurrences
	logic [33:0] srem_sh, strial;
	logic        sge;
	logic [33:0] rem_sh;
	logic        dge;
	assign srem_sh = {srem_q[31:0], n_q[61:60]};
	assign strial  = {1'b0, root_q, 2'b01};
	assign sge     = srem_sh >= strial;
	assign rem_sh  = {rem_q[32:0], low_q[31]};
	assign dge     = rem_sh >= {1'b0, dvsr_q};

	logic [43:0] adot;
	logic        szero, vsat;
	assign adot  = dot_q[44] ? 44'(-dot_q) : 44'(dot_q);
	assign szero = (sacc_q == 42'd0);
	assign vsat  = szero || ({adot, 10'd0} >= 54'(prod_q));

	// target and final selection
	logic [31:0]        sc;
	logic [18:0]        scc;
	logic signed [20:0] tw;
	logic [23:0]        atmp;
	logic [20:0]        dm;
	logic signed [20:0] step_w;
	logic signed [19:0] interp;
	logic [30:0]        vnew;
	logic [32:0]        den;
	assign sc   = prod_q[47:16];
	assign scc  = (sc > 32'(cfg.pmax)) ? cfg.pmax : sc[18:0];
	assign tw   = vneg_q ? 21'(PITCH_ONE) - $signed({2'b0, scc})
	                     : 21'(PITCH_ONE) + $signed({2'b0, scc});
	assign atmp = prod_q[39:16];
	assign dm   = prod_q[36:16];
	assign step_w = gap[20] ? 21'(smooth_q) - $signed(dm) : 21'(smooth_q) + $signed(dm);
	assign interp = ((cfg.speed == 24'd0) || (gap_mag <= SNAP_GAP)) ? tgt_q : step_w[19:0];
	assign vnew = vsat_q ? vmag_q : low_q[30:0];
	assign den  = vneg_q ? SOUND_Q16 + 33'(vnew) : SOUND_Q16 - 33'(vnew);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				for (int i = 0; i < 3; i++) begin
					d_q[i]  <= 25'(lp[i]) - 25'(sp[i]);
					dv_q[i] <= 22'(sv[i]) - 22'(lv[i]);
				end
			end
			OP_SHIFT: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i]   <= 20'(dmag[i] >> shamt);
					sgn_q[i] <= d_q[i][24];
				end
				sacc_q <= '0;
				dot_q  <= '0;
			end
			OP_MUL_SQ, OP_MUL_DOT, OP_MUL_LIM, OP_MUL_SC, OP_MUL_ALPHA, OP_MUL_GAP: begin
				prod_q <= mul_full[49:0];
			end
			OP_ACC_SQ:  sacc_q <= sacc_q + 42'(prod_q[39:0]);
			OP_ACC_DOT: dot_q  <= dot_q + prod_q[44:0];
			OP_SQRT_INIT: begin
				n_q    <= {sacc_q, 20'd0};
				srem_q <= '0;
				root_q <= '0;
			end
			OP_SQRT_STEP: begin
				n_q    <= {n_q[59:0], 2'b00};
				srem_q <= sge ? srem_sh - strial : srem_sh;
				root_q <= {root_q[29:0], sge};
			end
			OP_CMP_LIM: begin
				vsat_q <= vsat;
				vneg_q <= dot_q[44];
				vmag_q <= szero ? 31'd0 : {cfg.vlimit, 16'd0};
			end
			OP_DIV1_INIT: begin
				rem_q  <= adot[39:6];
				low_q  <= {adot[5:0], 26'd0};
				dvsr_q <= {2'd0, root_q};
			end
			OP_DIV_STEP: begin
				rem_q <= dge ? rem_sh - {1'b0, dvsr_q} : rem_sh;
				low_q <= {low_q[30:0], dge};
			end
			OP_DIV2_INIT: begin
				rem_q  <= {19'd0, vnew[30:16]};
				low_q  <= {vnew[15:0], 16'd0};
				dvsr_q <= den;
			end
			OP_TGT: begin
				if (tw > 21'sd524287) tgt_q <= 20'sd524287;
				else if (tw < -21'sd524288) tgt_q <= -20'sd524288;
				else tgt_q <= tw[19:0];
			end
			OP_ALPHA: alpha_q <= (atmp > 24'd65536) ? 17'd65536 : atmp[16:0];
			default: ;
		endcase
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= PITCH_ONE;
			init_q   <= 1'b0;
			valid_q  <= 1'b0;
			res_q    <= '0;
		end else begin
			if (cmd.op == OP_FINAL) begin
				valid_q <= 1'b1;
				if (!init_q) begin
					init_q   <= 1'b1;
					smooth_q <= tgt_q;
					res_q    <= tgt_q;
				end else if (cfg.smooth_on) begin
					smooth_q <= interp;
					res_q    <= interp;
				end else begin
					res_q <= tgt_q;
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_data      = {4'd0, res_q};
	assign out_valid     = valid_q;
	assign stat.vsat     = vsat;
	assign stat.out_free = !valid_q || out_ready;

endmodule

/* rtl/doppler_pitch_smoother.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doppler_pitch_smoother
// Doppler pitch factor from source/listener motion, with optional smoothing.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  12 position and velocity fields, 272 bits
// m_axis    out  m_tvalid/m_tready  pitch_scale, 20 bit signed Q16
// cfg       in   cfg_we             cfg_addr selects register, cfg_wdata
//
// One transaction at a time. Most of the work is the 31-step square root and
// one or two 32-step restoring divides in the datapath (one when the relative
// speed clamps); one shared multiplier serves every product. A new
// transaction is accepted while the last result still waits in the output
// register; the sequencer holds at its last step if that register is still
// full. Reset clears the smoothing state to pitch one.
// ----------------------------------------------------------------------------
module doppler_pitch_smoother import dps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// source_pos_x,y,z (24 each), source_vel_x,y,z (21 each),
	// listener_pos_x,y,z (24 each), listener_vel_x,y,z (21 each), 2 zero bits
	input  logic [IN_W-1:0]    s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	// pitch_scale (20), 4 zero bits
	output logic [OUT_W-1:0]   m_tdata,
	input  logic               cfg_we,
	input  logic [CFG_A_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]   cfg_wdata
);

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;

	// Configuration registers: write masked to width, unknown index dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.intensity <= RST_INTENSITY;
			cfg_q.smooth_on <= 1'b0;
			cfg_q.speed     <= RST_SPEED;
			cfg_q.vlimit    <= RST_VLIMIT;
			cfg_q.pmax      <= RST_PMAX;
			cfg_q.tick      <= RST_TICK;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_INTENSITY: cfg_q.intensity <= cfg_wdata;
				CFG_SMOOTH_ON: cfg_q.smooth_on <= cfg_wdata[0];
				CFG_SPEED:     cfg_q.speed     <= cfg_wdata;
				CFG_VLIMIT:    cfg_q.vlimit    <= cfg_wdata[14:0];
				CFG_PMAX:      cfg_q.pmax      <= cfg_wdata[18:0];
				CFG_TICK:      cfg_q.tick      <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Sequencer: issues one datapath command per clock, but holds at its last step while the output register is full.
	dps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: holds the item, the recurrences, smoothing state and result.
	dps_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg       (cfg_q),
		.in_data   (s_tdata),
		.out_data  (m_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready)
	);

endmodule

/* verif/doppler_pitch_smoother_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doppler_pitch_smoother_tb
// Self-checking bench: drives position/velocity transactions with random
// gaps, predicts each pitch factor with an independent fixed-point model
// and compares every output transaction against it in order.
// ----------------------------------------------------------------------------
module doppler_pitch_smoother_tb;
	import dps_pkg::*;

	localparam int WATCHDOG = 20000;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [OUT_W-1:0]   m_tdata;
	logic               cfg_we;
	logic [CFG_A_W-1:0] cfg_addr;
	logic [CFG_W-1:0]   cfg_wdata;

	// motion of one source and one listener, in field order
	typedef struct {
		logic signed [23:0] sp[3];
		logic signed [20:0] sv[3];
		logic signed [23:0] lp[3];
		logic signed [20:0] lv[3];
	} motion_t;

	// predictor copy of the registers and smoothing state
	cfg_t               pcfg;
	logic signed [19:0] pitch_state;
	bit                 pitch_init;

	logic signed [19:0] pitch_q[$];
	int                 errors;
	int                 idle_cycles;
	int                 recv_wait;
	bit                 recv_stall_on;

	doppler_pitch_smoother u_top (.*);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// plain shift-subtract square root of a wide value
	function automatic longint unsigned root_of(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint signed doppler_target(motion_t m);
		longint signed d[3], dv[3], dot, t;
		longint unsigned mx, sq, mg, lq, adot, vm, q, r, den, dev, sc;
		int sh;
		mx = 0; sq = 0; dot = 0; sh = 0;
		for (int i = 0; i < 3; i++) begin
			d[i]  = longint'(m.lp[i]) - longint'(m.sp[i]);
			dv[i] = longint'(m.sv[i]) - longint'(m.lv[i]);
			mg = d[i] < 0 ? -d[i] : d[i];
			if (mg > mx) mx = mg;
		end
		while ((mx >> sh) >= (64'd1 << 20)) sh++;
		for (int i = 0; i < 3; i++) begin
			mg = (d[i] < 0 ? -d[i] : d[i]) >> sh;
			d[i] = d[i] < 0 ? -longint'(mg) : longint'(mg);
			sq += mg * mg;
			dot += dv[i] * d[i];
		end
		if (sq == 0) return 65536;
		lq = root_of(sq << 20);
		adot = dot < 0 ? -dot : dot;
		if (adot * 1024 >= 64'(pcfg.vlimit) * lq) begin
			vm = 64'(pcfg.vlimit) << 16;
		end else begin
			q = (adot << 10) / lq;
			r = (adot << 10) % lq;
			vm = (q << 16) + ((r << 16) / lq);
		end
		den = dot < 0 ? 64'd2162688000 + vm : 64'd2162688000 - vm;
		dev = (vm << 16) / den;
		sc = (dev * pcfg.intensity) >> 16;
		if (sc > pcfg.pmax) sc = pcfg.pmax;
		t = dot < 0 ? 65536 - longint'(sc) : 65536 + longint'(sc);
		if (t < -524288) t = -524288;
		if (t > 524287) t = 524287;
		return t;
	endfunction

	// advance the smoothing state by one transaction and return the pitch
	function automatic logic signed [19:0] predict_pitch(motion_t m);
		longint signed tgt, cur, gap;
		longint unsigned alpha, gm;
		tgt = doppler_target(m);
		if (!pitch_init) begin
			pitch_init = 1;
			pitch_state = tgt;
			return tgt;
		end
		if (!pcfg.smooth_on) return tgt;
		cur = pitch_state;
		gap = tgt - cur;
		gm = gap < 0 ? -gap : gap;
		if (pcfg.speed == 0 || gm <= 6) begin
			pitch_state = tgt;
		end else begin
			alpha = (64'(pcfg.tick) * pcfg.speed) >> 16;
			if (alpha > 65536) alpha = 65536;
			gm = (gm * alpha) >> 16;
			pitch_state = gap < 0 ? cur - longint'(gm) : cur + longint'(gm);
		end
		return pitch_state;
	endfunction

	// drop the input and let every outstanding result drain
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pitch_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	// write one register; the block must be idle
	task automatic write_reg(logic [CFG_A_W-1:0] a, logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= a;
		cfg_wdata <= v;
		case (a)
			CFG_INTENSITY: pcfg.intensity = v[23:0];
			CFG_SMOOTH_ON: pcfg.smooth_on = v[0];
			CFG_SPEED:     pcfg.speed     = v[23:0];
			CFG_VLIMIT:    pcfg.vlimit    = v[14:0];
			CFG_PMAX:      pcfg.pmax      = v[18:0];
			CFG_TICK:      pcfg.tick      = v[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// send one transaction after a random gap, then record its expectation
	task automatic send_motion(motion_t m);
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {2'b0, m.lv[2], m.lv[1], m.lv[0], m.lp[2], m.lp[1], m.lp[0],
			m.sv[2], m.sv[1], m.sv[0], m.sp[2], m.sp[1], m.sp[0]};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pitch_q.push_back(predict_pitch(m));
	endtask

	function automatic motion_t rand_motion(int pos_bits, int vel_bits);
		motion_t m;
		for (int i = 0; i < 3; i++) begin
			m.sp[i] = 24'($signed($urandom) >>> (32 - pos_bits));
			m.lp[i] = 24'($signed($urandom) >>> (32 - pos_bits));
			m.sv[i] = 21'($signed($urandom) >>> (32 - vel_bits));
			m.lv[i] = 21'($signed($urandom) >>> (32 - vel_bits));
		end
		return m;
	endfunction

	function automatic motion_t still_motion();
		motion_t m;
		for (int i = 0; i < 3; i++) begin
			m.sp[i] = 0; m.lp[i] = 0; m.sv[i] = 0; m.lv[i] = 0;
		end
		return m;
	endfunction

	// corners: coincident points, full-scale extremes, clamp both ways
	task automatic test_directed();
		motion_t m;
		send_motion(still_motion());
		m = still_motion();
		m.lp[0] = 100;
		m.sv[0] = 21'sd3000;
		send_motion(m);
		m.sv[0] = -21'sd3000;
		send_motion(m);
		m.sv[0] = 21'sh0FFFFF;
		m.lv[0] = 21'sh100000;
		send_motion(m);
		m.sv[0] = 21'sh100000;
		m.lv[0] = 21'sh0FFFFF;
		send_motion(m);
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 3; i++) begin
				m.sp[i] = k[0] ? 24'sh800000 : 24'sh7FFFFF;
				m.lp[i] = k[0] ? 24'sh7FFFFF : 24'sh800000;
				m.sv[i] = k[1] ? 21'sh100000 : 21'sh0FFFFF;
				m.lv[i] = k[1] ? 21'sh0FFFFF : 21'sh100000;
			end
			send_motion(m);
		end
		m = still_motion();
		m.lp[2] = 1;
		m.sv[2] = 1;
		send_motion(m);
		m = still_motion();
		m.sp[0] = 5; m.lp[0] = 5; m.sv[0] = 21'sd9000;
		send_motion(m);
		wait_idle();
	endtask

	// run a batch of random motion under the current register setting
	task automatic run_random(int n);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 5))
				0: send_motion(rand_motion(24, 21));
				1: send_motion(rand_motion(12, 16));
				2: send_motion(rand_motion(24, 14));
				3: send_motion(rand_motion(6, 21));
				default: send_motion(rand_motion(18, 15));
			endcase
		end
		wait_idle();
	endtask

	// extreme and mid settings of every register, smoothing off and on
	task automatic test_register_sweep();
		write_reg(CFG_SMOOTH_ON, 24'd1);
		run_random(200);
		write_reg(CFG_INTENSITY, 24'hFFFFFF);
		write_reg(CFG_PMAX, 24'd262144);
		write_reg(CFG_VLIMIT, 24'd32000);
		run_random(200);
		write_reg(CFG_PMAX, 24'h7FFFF);
		write_reg(CFG_VLIMIT, 24'h7FFF);
		run_random(150);
		write_reg(CFG_INTENSITY, 24'd0);
		write_reg(CFG_SPEED, 24'd0);
		run_random(100);
		write_reg(CFG_INTENSITY, 24'd131072);
		write_reg(CFG_PMAX, 24'd0);
		write_reg(CFG_VLIMIT, 24'd0);
		run_random(100);
		write_reg(CFG_PMAX, 24'd100000);
		write_reg(CFG_VLIMIT, 24'd500);
		write_reg(CFG_SPEED, 24'hFFFFFF);
		write_reg(CFG_TICK, 24'hFFFF);
		run_random(200);
		write_reg(CFG_TICK, 24'd0);
		run_random(100);
		write_reg(CFG_TICK, 24'd20000);
		write_reg(CFG_SPEED, 24'd65536);
		run_random(250);
		write_reg(CFG_SMOOTH_ON, 24'd0);
		write_reg(CFG_INTENSITY, 24'd300000);
		run_random(200);
		write_reg(CFG_SMOOTH_ON, 24'd1);
		write_reg(CFG_TICK, 24'd1092);
		write_reg(CFG_SPEED, 24'd327680);
		run_random(300);
	endtask

	// compare each output transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pitch_q.size() == 0) begin
				$display("%0t: unexpected pitch %0d", $time, $signed(m_tdata[19:0]));
				errors++;
			end else begin
				if (m_tdata !== {4'b0, pitch_q[0]}) begin
					$display("%0t: pitch expected %0d actual %0d", $time,
						pitch_q[0], $signed(m_tdata[19:0]));
					errors++;
				end
				void'(pitch_q.pop_front());
			end
		end
	end

	// receiver stalls: draw a random wait before each result is taken,
	// with stall-free stretches
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			recv_wait <= 0;
		end else if (m_tvalid && m_tready) begin
			m_tready  <= 1'b0;
			recv_wait <= recv_stall_on ? int'($urandom_range(0, 7)) : 0;
		end else if (!m_tready) begin
			if (recv_wait == 0) m_tready <= 1'b1;
			else recv_wait <= recv_wait - 1;
		end
	end

	always @(posedge clk) begin
		if ($urandom_range(0, 499) == 0) recv_stall_on <= ~recv_stall_on;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = CFG_INTENSITY;
		cfg_wdata = '0;
		errors = 0;
		idle_cycles = 0;
		recv_stall_on = 1'b1;
		pcfg = '{RST_INTENSITY, 1'b0, RST_SPEED, RST_VLIMIT, RST_PMAX, RST_TICK};
		pitch_state = PITCH_ONE;
		pitch_init = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_register_sweep();
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
